// ----- rtl/core/asd_pkg.sv -----
// Shared types and constants for the accelerometer stillness detector.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package asd_pkg;

    // Sample format and window length
    localparam int SAMPLE_BITS = 16;
    localparam int WINDOW      = 5;

    // Fixed field widths
    localparam int THR_W  = 16;
    localparam int TIME_W = 32;
    localparam int DATA_W = 32;

    // Derived widths
    localparam int MAG_W   = SAMPLE_BITS;              // floor sqrt of a 2*S bit sum
    localparam int RAD_W   = 2 * SAMPLE_BITS;          // sum of three squares
    localparam int ITER_W  = $clog2(SAMPLE_BITS);      // root iteration counter
    localparam int CNT_W   = $clog2(WINDOW + 1);       // fill count, saturates at WINDOW
    localparam int SLOT_W  = $clog2(WINDOW);           // window write slot
    localparam int SUM_W   = MAG_W + CNT_W;            // running sum of magnitudes
    localparam int SUMSQ_W = 2 * MAG_W + CNT_W;        // running sum of squares
    localparam int MUL_W   = (SUM_W > THR_W) ? SUM_W : THR_W;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int CMP_W   = 2 * MUL_W + 2 * CNT_W;    // spread and limit compare

    // Stream word widths
    localparam int IN_TDATA_W  = ((3 * SAMPLE_BITS + TIME_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = 8;

    // Queue between front and back
    localparam int QDEPTH  = 2;
    localparam int QIDX_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_THRESHOLD = 1'b0,
        CFG_HOLD_TIME = 1'b1
    } cfg_index_t;

    // Configuration values seen by the back end
    typedef struct packed {
        logic [THR_W-1:0]  threshold;
        logic [TIME_W-1:0] hold_time_ms;
    } cfg_t;

    // One classified sample as it travels through the queue
    typedef struct packed {
        logic [MAG_W-1:0]  mag;
        logic [TIME_W-1:0] now_ms;
    } q_item_t;

endpackage

// ----- rtl/core/asd_front.sv -----
// Front end: accepts a sample, sums the three squared axes and takes the
// integer square root one bit pair per cycle. Depends on asd_pkg.
`timescale 1ns / 1ps

module asd_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [asd_pkg::SAMPLE_BITS-1:0] accel_x,
    input  logic signed [asd_pkg::SAMPLE_BITS-1:0] accel_y,
    input  logic signed [asd_pkg::SAMPLE_BITS-1:0] accel_z,
    input  logic [asd_pkg::TIME_W-1:0]        now_ms,
    output logic                              push_valid,
    input  logic                              push_ready,
    output asd_pkg::q_item_t                  push_item
);
    import asd_pkg::*;

    typedef enum logic [1:0] {
        F_IDLE,
        F_SQUARE,
        F_ROOT,
        F_PUSH
    } f_state_t;

    f_state_t                 state_reg;
    logic [SAMPLE_BITS-1:0]   abs_reg [3];
    logic [1:0]               axis_reg;
    logic [RAD_W-1:0]         acc_reg;
    logic [RAD_W-1:0]         rem_reg;
    logic [RAD_W-1:0]         res_reg;
    logic [RAD_W-1:0]         bit_reg;
    logic [ITER_W-1:0]        iter_reg;
    logic [TIME_W-1:0]        now_reg;

    logic [SAMPLE_BITS-1:0]   abs_x;
    logic [SAMPLE_BITS-1:0]   abs_y;
    logic [SAMPLE_BITS-1:0]   abs_z;
    logic [RAD_W-1:0]         sq;
    logic [RAD_W-1:0]         acc_sum;
    logic [RAD_W:0]           trial;
    logic                     take;

    // Absolute values; the most negative code maps to 2^(S-1), which fits unsigned
    assign abs_x = accel_x[SAMPLE_BITS-1] ? SAMPLE_BITS'(-accel_x) : SAMPLE_BITS'(accel_x);
    assign abs_y = accel_y[SAMPLE_BITS-1] ? SAMPLE_BITS'(-accel_y) : SAMPLE_BITS'(accel_y);
    assign abs_z = accel_z[SAMPLE_BITS-1] ? SAMPLE_BITS'(-accel_z) : SAMPLE_BITS'(accel_z);

    // One square per cycle from the head of the axis shift line
    assign sq      = RAD_W'(abs_reg[0]) * RAD_W'(abs_reg[0]);
    assign acc_sum = acc_reg + sq;

    // Restoring root step
    assign trial = {1'b0, res_reg} + {1'b0, bit_reg};
    assign take  = ({1'b0, rem_reg} >= trial);

    assign in_ready            = (state_reg == F_IDLE);
    assign push_valid          = (state_reg == F_PUSH);
    assign push_item.mag       = res_reg[MAG_W-1:0];
    assign push_item.now_ms    = now_reg;

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            for (int i = 0; i < 3; i++)
            begin
                abs_reg[i] <= '0;
            end
            axis_reg  <= '0;
            acc_reg   <= '0;
            rem_reg   <= '0;
            res_reg   <= '0;
            bit_reg   <= '0;
            iter_reg  <= '0;
            now_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (in_valid)
                    begin
                        abs_reg[0] <= abs_x;
                        abs_reg[1] <= abs_y;
                        abs_reg[2] <= abs_z;
                        now_reg    <= now_ms;
                        acc_reg    <= '0;
                        axis_reg   <= '0;
                        state_reg  <= F_SQUARE;
                    end
                end
                F_SQUARE:
                begin
                    acc_reg    <= acc_sum;
                    abs_reg[0] <= abs_reg[1];
                    abs_reg[1] <= abs_reg[2];
                    axis_reg   <= axis_reg + 2'd1;
                    if (axis_reg == 2'd2)
                    begin
                        rem_reg   <= acc_sum;
                        res_reg   <= '0;
                        bit_reg   <= RAD_W'(1) << (RAD_W - 2);
                        iter_reg  <= '0;
                        state_reg <= F_ROOT;
                    end
                end
                F_ROOT:
                begin
                    if (take)
                    begin
                        rem_reg <= rem_reg - trial[RAD_W-1:0];
                        res_reg <= (res_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        res_reg <= res_reg >> 1;
                    end
                    bit_reg  <= bit_reg >> 2;
                    iter_reg <= iter_reg + ITER_W'(1);
                    if (iter_reg == ITER_W'(SAMPLE_BITS - 1))
                    begin
                        state_reg <= F_PUSH;
                    end
                end
                F_PUSH:
                begin
                    if (push_ready)
                    begin
                        state_reg <= F_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- rtl/core/asd_fifo.sv -----
// Short queue of magnitudes and time stamps between front and back end.
// Depends on asd_pkg.
`timescale 1ns / 1ps

module asd_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  asd_pkg::q_item_t push_item,
    output logic             pop_valid,
    input  logic             pop_ready,
    output asd_pkg::q_item_t pop_item
);
    import asd_pkg::*;

    q_item_t           mem_reg [QDEPTH];
    logic [QIDX_W-1:0] wr_ptr_reg;
    logic [QIDX_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != QCNT_W'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QIDX_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QIDX_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

endmodule

// ----- rtl/core/asd_back.sv -----
// Back end: sliding window of magnitudes, running sums, spread test, hold
// timer and result register. Shares one multiplier over its steps. Depends on asd_pkg.
`timescale 1ns / 1ps

module asd_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pop_valid,
    output logic             pop_ready,
    input  asd_pkg::q_item_t pop_item,
    input  asd_pkg::cfg_t    cfg,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic             became_stationary,
    output logic             is_stationary,
    output logic             window_full
);
    import asd_pkg::*;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SQ_NEW,
        B_SQ_OLD,
        B_UPDATE,
        B_SQ_SUM,
        B_SQ_THR,
        B_LIMIT,
        B_DECIDE
    } b_state_t;

    b_state_t            state_reg;
    logic [MAG_W-1:0]    window_reg [WINDOW];
    logic [SLOT_W-1:0]   slot_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [SUMSQ_W-1:0]  sumsq_reg;
    logic [TIME_W-1:0]   last_reg;
    logic                flag_reg;
    logic [MAG_W-1:0]    mag_reg;
    logic [MAG_W-1:0]    old_reg;
    logic [TIME_W-1:0]   now_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [CMP_W-1:0]    sumsq5_reg;
    logic [CMP_W-1:0]    spread_reg;
    logic [CMP_W-1:0]    limit_reg;
    logic                out_valid_reg;
    logic                became_reg;
    logic                stat_reg;
    logic                full_reg;

    logic [MUL_W-1:0]    mul_a;
    logic [MUL_W-1:0]    mul_b;
    logic [PROD_W-1:0]   mul_p;
    logic [TIME_W-1:0]   elapsed;
    logic                full;
    logic                still;
    logic                hold_ok;
    logic                accept_time;
    logic                flag_next;
    logic                event_next;
    logic                out_free;
    logic                load_out;

    // Shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            B_SQ_NEW:
            begin
                mul_a = MUL_W'(mag_reg);
                mul_b = MUL_W'(mag_reg);
            end
            B_SQ_OLD:
            begin
                mul_a = MUL_W'(old_reg);
                mul_b = MUL_W'(old_reg);
            end
            B_SQ_SUM:
            begin
                mul_a = MUL_W'(sum_reg);
                mul_b = MUL_W'(sum_reg);
            end
            B_SQ_THR:
            begin
                mul_a = MUL_W'(cfg.threshold);
                mul_b = MUL_W'(cfg.threshold);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Stillness decision on the finished sums
    assign full        = (count_reg == CNT_W'(WINDOW));
    assign elapsed     = now_reg - last_reg;
    assign still       = (spread_reg < limit_reg);
    assign hold_ok     = (elapsed >= cfg.hold_time_ms);
    assign accept_time = full && still && hold_ok;

    always_comb
    begin
        flag_next  = flag_reg;
        event_next = 1'b0;
        if (full)
        begin
            if (still)
            begin
                if (hold_ok && !flag_reg)
                begin
                    flag_next  = 1'b1;
                    event_next = 1'b1;
                end
            end
            else
            begin
                flag_next = 1'b0;
            end
        end
    end

    assign out_free          = !out_valid_reg || m_tready;
    assign load_out          = (state_reg == B_DECIDE) && out_free;
    assign pop_ready         = (state_reg == B_IDLE);
    assign m_tvalid          = out_valid_reg;
    assign became_stationary = became_reg;
    assign is_stationary     = stat_reg;
    assign window_full       = full_reg;

    // Sequencer, window, sums and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            for (int i = 0; i < WINDOW; i++)
            begin
                window_reg[i] <= '0;
            end
            slot_reg      <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
            sumsq_reg     <= '0;
            last_reg      <= '0;
            flag_reg      <= 1'b0;
            mag_reg       <= '0;
            old_reg       <= '0;
            now_reg       <= '0;
            prod_reg      <= '0;
            sumsq5_reg    <= '0;
            spread_reg    <= '0;
            limit_reg     <= '0;
            out_valid_reg <= 1'b0;
            became_reg    <= 1'b0;
            stat_reg      <= 1'b0;
            full_reg      <= 1'b0;
        end
        else
        begin
            // Result word valid: set on load, cleared once taken
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE:
                begin
                    if (pop_valid)
                    begin
                        mag_reg   <= pop_item.mag;
                        now_reg   <= pop_item.now_ms;
                        old_reg   <= window_reg[slot_reg];
                        state_reg <= B_SQ_NEW;
                    end
                end
                B_SQ_NEW:
                begin
                    prod_reg  <= mul_p;
                    sum_reg   <= sum_reg + SUM_W'(mag_reg) - SUM_W'(old_reg);
                    state_reg <= B_SQ_OLD;
                end
                B_SQ_OLD:
                begin
                    sumsq_reg <= sumsq_reg + prod_reg[SUMSQ_W-1:0];
                    prod_reg  <= mul_p;
                    state_reg <= B_UPDATE;
                end
                B_UPDATE:
                begin
                    sumsq_reg            <= sumsq_reg - prod_reg[SUMSQ_W-1:0];
                    window_reg[slot_reg] <= mag_reg;
                    if (slot_reg == SLOT_W'(WINDOW - 1))
                    begin
                        slot_reg <= '0;
                    end
                    else
                    begin
                        slot_reg <= slot_reg + SLOT_W'(1);
                    end
                    if (count_reg != CNT_W'(WINDOW))
                    begin
                        count_reg <= count_reg + CNT_W'(1);
                    end
                    state_reg <= B_SQ_SUM;
                end
                B_SQ_SUM:
                begin
                    prod_reg   <= mul_p;
                    sumsq5_reg <= CMP_W'(sumsq_reg) * CMP_W'(WINDOW);
                    state_reg  <= B_SQ_THR;
                end
                B_SQ_THR:
                begin
                    spread_reg <= sumsq5_reg - CMP_W'(prod_reg);
                    prod_reg   <= mul_p;
                    state_reg  <= B_LIMIT;
                end
                B_LIMIT:
                begin
                    limit_reg <= CMP_W'(prod_reg) * CMP_W'(WINDOW * WINDOW);
                    state_reg <= B_DECIDE;
                end
                B_DECIDE:
                begin
                    if (out_free)
                    begin
                        if (accept_time)
                        begin
                            last_reg <= now_reg;
                        end
                        flag_reg      <= flag_next;
                        became_reg    <= event_next;
                        stat_reg      <= flag_next;
                        full_reg      <= full;
                        state_reg     <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    // An event word always reports a full window and the stationary state
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && became_reg |-> stat_reg && full_reg)
        else $error("event word without stationary state or full window");

    // Entering stillness is reported in the word loaded on the same edge
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(flag_reg) |-> out_valid_reg && became_reg)
        else $error("stationary flag rose without an event word");

    // Fill count saturates at the window length
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(WINDOW))
        else $error("fill count beyond window length");

    // Write slot stays inside the window
    assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg < SLOT_W'(WINDOW))
        else $error("write slot outside window");

endmodule

// ----- rtl/core/accel_stillness_detector_top.sv -----
// Top level of the accelerometer stillness detector: stream ports, config
// registers, front end, queue and back end. Depends on asd_pkg, asd_front,
// asd_fifo and asd_back.
//
// Usage:
//   s_* : one input word per sample: three signed axes and a ms time stamp.
//   m_* : one result word per sample: event, stationary flag, window full.
//   cfg_*: register writes (threshold, hold time), always ready; write only
//          while no sample is in flight.
// Timing:
//   The front end squares the three axes in turn on one multiplier and
//   then takes one root bit per cycle in the iterative square root. That
//   root loop sets the throughput. The back end works on its shared
//   multiplier and overlaps the next sample's root through a two-word
//   queue.
// Reset: window, sums, time and flag clear; threshold 64, hold time 1000 ms.
// Stall: a stalled result word holds in its register; the back end then
//   waits, the queue fills and s_tready stays low while the front end holds
//   a word it cannot hand on.
`timescale 1ns / 1ps

module accel_stillness_detector_top (
    input  logic                                clk,
    input  logic                                rst_n,
    // accel_x [15:0], accel_y [31:16], accel_z [47:32], now_ms [79:48]
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [asd_pkg::IN_TDATA_W-1:0]      s_tdata,
    // became_stationary [0], is_stationary [1], window_full [2], zeros above
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [asd_pkg::OUT_TDATA_W-1:0]     m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  asd_pkg::cfg_index_t                 cfg_index,
    input  logic [asd_pkg::DATA_W-1:0]          cfg_data
);
    import asd_pkg::*;

    logic [THR_W-1:0]         threshold_reg;
    logic [TIME_W-1:0]        hold_time_reg;
    cfg_t                     cfg;
    logic signed [SAMPLE_BITS-1:0] accel_x;
    logic signed [SAMPLE_BITS-1:0] accel_y;
    logic signed [SAMPLE_BITS-1:0] accel_z;
    logic [TIME_W-1:0]        now_ms;
    logic                     push_valid;
    logic                     push_ready;
    q_item_t                  push_item;
    logic                     pop_valid;
    logic                     pop_ready;
    q_item_t                  pop_item;
    logic                     became_stationary;
    logic                     is_stationary;
    logic                     window_full;

    // Input word unpack
    assign accel_x = s_tdata[SAMPLE_BITS-1:0];
    assign accel_y = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign accel_z = s_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
    assign now_ms  = s_tdata[3*SAMPLE_BITS+TIME_W-1:3*SAMPLE_BITS];

    // Result word pack
    assign m_tdata = {(OUT_TDATA_W - 3)'(0), window_full, is_stationary, became_stationary};

    // Configuration registers
    assign cfg_ready        = 1'b1;
    assign cfg.threshold    = threshold_reg;
    assign cfg.hold_time_ms = hold_time_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THR_W'(64);
            hold_time_reg <= TIME_W'(1000);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_THRESHOLD: threshold_reg <= cfg_data[THR_W-1:0];
                CFG_HOLD_TIME: hold_time_reg <= cfg_data[TIME_W-1:0];
                default:
                begin
                    threshold_reg <= threshold_reg;
                end
            endcase
        end
    end

    asd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .accel_x    (accel_x),
        .accel_y    (accel_y),
        .accel_z    (accel_z),
        .now_ms     (now_ms),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    asd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    asd_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .pop_valid         (pop_valid),
        .pop_ready         (pop_ready),
        .pop_item          (pop_item),
        .cfg               (cfg),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .became_stationary (became_stationary),
        .is_stationary     (is_stationary),
        .window_full       (window_full)
    );

endmodule
